// ===== rtl/atan2_pkg.sv =====
// shared types, widths and fixed-point constants of the arctangent pipeline
package atan2_pkg;

  // port and datapath widths
  localparam int IN_W    = 32;
  localparam int FRAC_W  = 29;
  localparam int OUT_W   = 32;
  localparam int QF      = 60;
  localparam int QW      = 64;
  localparam int HW      = QW / 2;
  localparam int QBITS   = QF + 1;
  localparam int CW      = IN_W + 5;
  localparam int DW      = IN_W + 3;
  localparam int SHIFT   = QF - FRAC_W;
  localparam int NCOEF   = 21;
  localparam int NSTEP   = NCOEF - 1;
  localparam int IN_TD_W = ((2 * IN_W + 7) / 8) * 8;
  localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8;

  // decimal constants, scaled by 10^18
  localparam logic [63:0] DEC_ONE          = 64'd1000000000000000000;
  localparam logic [63:0] DEC_ATAN_HALF    = 64'd463647609000806116;
  localparam logic [63:0] DEC_ATAN_3HALF   = 64'd982793723247329067;
  localparam logic [63:0] DEC_PI           = 64'd3141592653589793238;

  localparam logic [63:0] COEF_DEC [NCOEF] = '{
    64'd333333333333333333, 64'd199999999999999999, 64'd142857142857142857,
    64'd111111111111111111, 64'd90909090909090909,  64'd76923076923076923,
    64'd66666666666666662,  64'd58823529411764454,  64'd52631578947355920,
    64'd47619047618567045,  64'd43478260855068916,  64'd39999999653506693,
    64'd37037030436227061,  64'd34482658185047909,  64'd32256845866214999,
    64'd30291305255230381,  64'd28482910936322424,  64'd26511385701218695,
    64'd23381127183313153,  64'd17211039939973303,  64'd7572335682370299
  };

  // decimal fraction to Q.60, rounded half up (elaboration only)
  function automatic logic [63:0] dec_to_q(input logic [63:0] num);
    logic [63:0] whole;
    logic [63:0] rem;
    logic [63:0] q;
    whole = '0;
    rem   = num;
    q     = '0;
    for (int i = 0; i < 8; i++) begin
      if (rem >= DEC_ONE && whole < 64'd7) begin
        rem   = rem - DEC_ONE;
        whole = whole + 64'd1;
      end
    end
    for (int i = 0; i < QBITS; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= DEC_ONE) begin
        rem  = rem - DEC_ONE;
        q[0] = 1'b1;
      end
    end
    q = (q + 64'd1) >> 1;
    return (whole << QF) + q;
  endfunction

  // signed series coefficient, odd terms negative
  function automatic logic signed [QW-1:0] coef_q(input int k);
    logic [63:0] v;
    v = dec_to_q(COEF_DEC[k]);
    return ((k & 1) != 0) ? -$signed(v) : $signed(v);
  endfunction

  localparam logic signed [QW-1:0] COEF_Q [NCOEF] = '{
    coef_q(0),  coef_q(1),  coef_q(2),  coef_q(3),  coef_q(4),  coef_q(5),
    coef_q(6),  coef_q(7),  coef_q(8),  coef_q(9),  coef_q(10), coef_q(11),
    coef_q(12), coef_q(13), coef_q(14), coef_q(15), coef_q(16), coef_q(17),
    coef_q(18), coef_q(19), coef_q(20)
  };

  localparam logic signed [QW-1:0] PI_Q         = $signed(dec_to_q(DEC_PI));
  localparam logic signed [QW-1:0] HALF_PI_Q    = (PI_Q + 64'sd1) >>> 1;
  localparam logic signed [QW-1:0] QUARTER_PI_Q = (PI_Q + 64'sd2) >>> 2;
  localparam logic signed [QW-1:0] ATAN_HALF_Q  = $signed(dec_to_q(DEC_ATAN_HALF));
  localparam logic signed [QW-1:0] ATAN_3HALF_Q = $signed(dec_to_q(DEC_ATAN_3HALF));
  localparam logic [QW-1:0] ANGLE_MAX_W = (PI_Q + (64'sd1 <<< (SHIFT - 1))) >>> SHIFT;
  localparam logic [OUT_W-1:0] ANGLE_MAX = ANGLE_MAX_W[OUT_W-1:0];

  // interval of |y|/|x|
  typedef enum logic [2:0] {
    SEC_ZERO,
    SEC_HALF,
    SEC_QUARTER,
    SEC_THREE_HALVES,
    SEC_RIGHT
  } sector_t;

  // per-word context that travels down the pipeline
  typedef struct packed {
    logic                   undef;
    logic                   neg_x;
    logic                   neg_y;
    sector_t                sector;
    logic signed [QW-1:0]   red;
    logic signed [QW-1:0]   sq;
    logic signed [QW-1:0]   poly;
  } ctx_t;

endpackage

// ===== rtl/two_argument_arctangent.sv =====
// two-argument arctangent: fully pipelined, one word per cycle
// path from input word to result word: front end, divider with rounding, r^2 multiplier,
//   the 20-step series, the two final products and the output registers
// throughput: one word per cycle; a stall at the output holds every stage in place
// reset: synchronous active-low rst_n clears all valid bits, no clearing pass
module two_argument_arctangent (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [atan2_pkg::IN_TD_W-1:0]       in_tdata,   // x_value, y_value
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [atan2_pkg::OUT_TD_W-1:0]      out_tdata,  // angle
  output logic                                out_tuser   // undefined
);
  import atan2_pkg::*;

  logic                 en;
  logic                 f_vld, f_neg;
  ctx_t                 f_ctx;
  logic [DW-1:0]        f_mag, f_den;
  logic                 d_vld;
  ctx_t                 d_ctx;
  logic                 s_vld;
  logic signed [QW-1:0] s_prod;
  ctx_t                 s_ctx, p_in_ctx;
  logic                 p_vld;
  ctx_t                 p_ctx;
  logic                 r_vld;
  logic signed [QW-1:0] r_prod;
  ctx_t                 r_ctx, c_ctx;
  logic                 m_vld;
  logic signed [QW-1:0] m_prod;
  ctx_t                 m_ctx;

  logic signed [QW-1:0] offset;
  logic signed [QW-1:0] sum_nxt, res_nxt, res_r;
  logic                 f1_vld_r, undef_r, negy_r;
  logic signed [QW-1:0] clamped;
  logic [QW-1:0]        rnd_mag;
  logic [OUT_W-1:0]     ang;
  logic [OUT_W-1:0]     angle_nxt;
  logic                 out_vld_r;
  logic [OUT_W-1:0]     angle_r;
  logic                 undef_out_r;

  // whole pipeline advances unless the output word is held
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  atan2_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (in_tvalid),
    .x_i       (in_tdata[IN_W-1:0]),
    .y_i       (in_tdata[2*IN_W-1:IN_W]),
    .out_vld   (f_vld),
    .ctx_o     (f_ctx),
    .num_neg_o (f_neg),
    .num_mag_o (f_mag),
    .den_o     (f_den)
  );

  atan2_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (f_vld),
    .ctx_i     (f_ctx),
    .num_neg_i (f_neg),
    .num_mag_i (f_mag),
    .den_i     (f_den),
    .out_vld   (d_vld),
    .ctx_o     (d_ctx)
  );

  // r^2
  atan2_qmul u_sq (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (d_vld),
    .a_i     (d_ctx.red),
    .b_i     (d_ctx.red),
    .ctx_i   (d_ctx),
    .out_vld (s_vld),
    .prod_o  (s_prod),
    .ctx_o   (s_ctx)
  );

  always_comb begin
    p_in_ctx    = s_ctx;
    p_in_ctx.sq = s_prod;
  end

  atan2_poly u_poly (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s_vld),
    .ctx_i   (p_in_ctx),
    .out_vld (p_vld),
    .ctx_o   (p_ctx)
  );

  // r^3
  atan2_qmul u_cube (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (p_vld),
    .a_i     (p_ctx.red),
    .b_i     (p_ctx.sq),
    .ctx_i   (p_ctx),
    .out_vld (r_vld),
    .prod_o  (r_prod),
    .ctx_o   (r_ctx)
  );

  always_comb begin
    c_ctx    = r_ctx;
    c_ctx.sq = r_prod;
  end

  // r^3 * P(r^2)
  atan2_qmul u_tail (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (r_vld),
    .a_i     (c_ctx.sq),
    .b_i     (c_ctx.poly),
    .ctx_i   (c_ctx),
    .out_vld (m_vld),
    .prod_o  (m_prod),
    .ctx_o   (m_ctx)
  );

  // interval offset
  always_comb begin
    case (m_ctx.sector)
      SEC_ZERO:         offset = '0;
      SEC_HALF:         offset = ATAN_HALF_Q;
      SEC_QUARTER:      offset = QUARTER_PI_Q;
      SEC_THREE_HALVES: offset = ATAN_3HALF_Q;
      SEC_RIGHT:        offset = HALF_PI_Q;
      default:          offset = '0;
    endcase
  end

  // first-quadrant angle, mirrored for negative x
  assign sum_nxt = offset + m_ctx.red - m_prod;
  assign res_nxt = m_ctx.neg_x ? (PI_Q - sum_nxt) : sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r   <= res_nxt;
      undef_r <= m_ctx.undef;
      negy_r  <= m_ctx.neg_y;
    end
  end

  // clamp to 0..pi, round to output scale, apply sign of y, zero angle when undefined
  assign clamped = (res_r < 0) ? '0 : ((res_r > PI_Q) ? PI_Q : res_r);
  assign rnd_mag = ($unsigned(clamped) + (QW'(1) << (SHIFT - 1))) >> SHIFT;
  assign ang     = rnd_mag[OUT_W-1:0];

  always_comb begin
    if (undef_r) begin
      angle_nxt = '0;
    end else if (negy_r) begin
      angle_nxt = ~ang + 1'b1;
    end else begin
      angle_nxt = ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r     <= angle_nxt;
      undef_out_r <= undef_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TD_W'(angle_r);
  assign out_tuser  = undef_out_r;

endmodule

// ===== rtl/atan2_front.sv =====
// front end: sign strip, interval select and reduced-argument numerator/denominator
module atan2_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic [atan2_pkg::IN_W-1:0]         x_i,
  input  logic [atan2_pkg::IN_W-1:0]         y_i,
  output logic                               out_vld,
  output atan2_pkg::ctx_t                    ctx_o,
  output logic                               num_neg_o,
  output logic [atan2_pkg::DW-1:0]           num_mag_o,
  output logic [atan2_pkg::DW-1:0]           den_o
);
  import atan2_pkg::*;

  logic              a_vld_r;
  logic [IN_W-1:0]   ax_r, ay_r;
  logic              nx_r, ny_r;
  logic [IN_W-1:0]   ax_nxt, ay_nxt;

  logic              b_vld_r;
  ctx_t              ctx_r, ctx_nxt;
  logic              neg_r, neg_nxt;
  logic [DW-1:0]     mag_r, mag_nxt;
  logic [DW-1:0]     den_r, den_nxt;

  logic [CW-1:0]     axc, ayc;
  logic [DW-1:0]     axd, ayd;

  // magnitudes, most negative input maps to 2^(IN_W-1)
  assign ax_nxt = x_i[IN_W-1] ? (~x_i + 1'b1) : x_i;
  assign ay_nxt = y_i[IN_W-1] ? (~y_i + 1'b1) : y_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
      nx_r <= x_i[IN_W-1];
      ny_r <= y_i[IN_W-1];
    end
  end

  // interval select by exact integer compares
  assign axc = CW'(ax_r);
  assign ayc = CW'(ay_r);
  assign axd = DW'(ax_r);
  assign ayd = DW'(ay_r);

  always_comb begin
    ctx_nxt        = '0;
    ctx_nxt.undef  = (ax_r == '0) && (ay_r == '0);
    ctx_nxt.neg_x  = nx_r;
    ctx_nxt.neg_y  = ny_r;
    neg_nxt        = 1'b0;
    mag_nxt        = ayd;
    den_nxt        = axd;
    if (ayc < (axc + (axc << 1))) begin
      if ((ayc + (ayc << 1)) <= axc) begin
        ctx_nxt.sector = SEC_ZERO;
      end else if ((ayc << 4) < ((axc << 3) + (axc << 1) + axc)) begin
        ctx_nxt.sector = SEC_HALF;
        neg_nxt        = (ayd << 1) < axd;
        mag_nxt        = neg_nxt ? (axd - (ayd << 1)) : ((ayd << 1) - axd);
        den_nxt        = (axd << 1) + ayd;
      end else if ((ayc << 4) < ((axc << 4) + (axc << 1) + axc)) begin
        ctx_nxt.sector = SEC_QUARTER;
        neg_nxt        = ayd < axd;
        mag_nxt        = neg_nxt ? (axd - ayd) : (ayd - axd);
        den_nxt        = axd + ayd;
      end else begin
        ctx_nxt.sector = SEC_THREE_HALVES;
        neg_nxt        = (ayd << 1) < ((axd << 1) + axd);
        mag_nxt        = neg_nxt ? (((axd << 1) + axd) - (ayd << 1))
                                 : ((ayd << 1) - ((axd << 1) + axd));
        den_nxt        = (axd << 1) + (ayd << 1) + ayd;
      end
    end else begin
      ctx_nxt.sector = SEC_RIGHT;
      neg_nxt        = 1'b1;
      mag_nxt        = axd;
      den_nxt        = ayd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r <= ctx_nxt;
      neg_r <= neg_nxt;
      mag_r <= mag_nxt;
      den_r <= den_nxt;
    end
  end

  assign out_vld   = b_vld_r;
  assign ctx_o     = ctx_r;
  assign num_neg_o = neg_r;
  assign num_mag_o = mag_r;
  assign den_o     = den_r;

endmodule

// ===== rtl/atan2_div.sv =====
// pipelined restoring divider, one quotient bit per stage, then rounding
module atan2_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  atan2_pkg::ctx_t            ctx_i,
  input  logic                       num_neg_i,
  input  logic [atan2_pkg::DW-1:0]   num_mag_i,
  input  logic [atan2_pkg::DW-1:0]   den_i,
  output logic                       out_vld,
  output atan2_pkg::ctx_t            ctx_o
);
  import atan2_pkg::*;

  logic              vld_r [QBITS];
  ctx_t              ctx_r [QBITS];
  logic              neg_r [QBITS];
  logic [DW-1:0]     rem_r [QBITS];
  logic [DW-1:0]     den_r [QBITS];
  logic [QBITS-1:0]  q_r   [QBITS];

  logic              o_vld_r;
  ctx_t              o_ctx_r, o_ctx_nxt;
  logic [QBITS:0]    rnd;

  for (genvar s = 0; s < QBITS; s++) begin : g_stage
    logic              p_vld;
    ctx_t              p_ctx;
    logic              p_neg;
    logic [DW-1:0]     p_rem;
    logic [DW-1:0]     p_den;
    logic [QBITS-1:0]  p_q;
    logic [DW:0]       trial;
    logic [DW:0]       diff;
    logic              take;

    if (s == 0) begin : g_first
      assign p_vld = in_vld;
      assign p_ctx = ctx_i;
      assign p_neg = num_neg_i;
      assign p_rem = num_mag_i;
      assign p_den = den_i;
      assign p_q   = '0;
    end else begin : g_next
      assign p_vld = vld_r[s-1];
      assign p_ctx = ctx_r[s-1];
      assign p_neg = neg_r[s-1];
      assign p_rem = rem_r[s-1];
      assign p_den = den_r[s-1];
      assign p_q   = q_r[s-1];
    end

    // shift in one bit, subtract when it fits
    assign trial = {p_rem, 1'b0};
    assign take  = trial >= {1'b0, p_den};
    assign diff  = trial - {1'b0, p_den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctx_r[s] <= p_ctx;
        neg_r[s] <= p_neg;
        den_r[s] <= p_den;
        rem_r[s] <= take ? diff[DW-1:0] : trial[DW-1:0];
        q_r[s]   <= {p_q[QBITS-2:0], take};
      end
    end
  end

  // round half away from zero, apply numerator sign
  assign rnd = {1'b0, q_r[QBITS-1]} + 1'b1;

  always_comb begin
    o_ctx_nxt     = ctx_r[QBITS-1];
    o_ctx_nxt.red = neg_r[QBITS-1] ? -$signed(QW'(rnd[QBITS:1]))
                                   : $signed(QW'(rnd[QBITS:1]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (en) begin
      o_vld_r <= vld_r[QBITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_ctx_r <= o_ctx_nxt;
    end
  end

  assign out_vld = o_vld_r;
  assign ctx_o   = o_ctx_r;

endmodule

// ===== rtl/atan2_qmul.sv =====
// three-stage signed Q.60 multiplier, rounded half away from zero
module atan2_qmul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic signed [atan2_pkg::QW-1:0]   a_i,
  input  logic signed [atan2_pkg::QW-1:0]   b_i,
  input  atan2_pkg::ctx_t                   ctx_i,
  output logic                              out_vld,
  output logic signed [atan2_pkg::QW-1:0]   prod_o,
  output atan2_pkg::ctx_t                   ctx_o
);
  import atan2_pkg::*;

  localparam logic [2*QW-1:0] RND = (2*QW)'(1) << (QF - 1);

  logic [QW-1:0]     ua, ub;
  logic [QW-1:0]     p00_nxt, p01_nxt, p10_nxt, p11_nxt;
  logic [QW-1:0]     p00_r, p01_r, p10_r, p11_r;
  logic              s1_vld_r, s2_vld_r, s3_vld_r;
  logic              sgn1_r, sgn2_r;
  ctx_t              ctx1_r, ctx2_r, ctx3_r;
  logic [2*QW-1:0]   sum;
  logic [QW-1:0]     res_r;
  logic signed [QW-1:0] prod_r;

  // magnitudes and 32x32 partial products
  assign ua      = a_i[QW-1] ? (~a_i + 1'b1) : a_i;
  assign ub      = b_i[QW-1] ? (~b_i + 1'b1) : b_i;
  assign p00_nxt = ua[HW-1:0]  * ub[HW-1:0];
  assign p01_nxt = ua[HW-1:0]  * ub[QW-1:HW];
  assign p10_nxt = ua[QW-1:HW] * ub[HW-1:0];
  assign p11_nxt = ua[QW-1:HW] * ub[QW-1:HW];

  // partial product sum with rounding
  assign sum = {{QW{1'b0}}, p00_r}
             + ({{QW{1'b0}}, p01_r} << HW)
             + ({{QW{1'b0}}, p10_r} << HW)
             + {p11_r, {QW{1'b0}}}
             + RND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r  <= p00_nxt;
      p01_r  <= p01_nxt;
      p10_r  <= p10_nxt;
      p11_r  <= p11_nxt;
      sgn1_r <= a_i[QW-1] ^ b_i[QW-1];
      ctx1_r <= ctx_i;
      res_r  <= {1'b0, sum[QF+QW-2:QF]};
      sgn2_r <= sgn1_r;
      ctx2_r <= ctx1_r;
      prod_r <= sgn2_r ? -$signed(res_r) : $signed(res_r);
      ctx3_r <= ctx2_r;
    end
  end

  assign out_vld = s3_vld_r;
  assign prod_o  = prod_r;
  assign ctx_o   = ctx3_r;

endmodule

// ===== rtl/atan2_poly.sv =====
// horner chain of the series in r^2, one multiply and one add per step
module atan2_poly (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  atan2_pkg::ctx_t   ctx_i,
  output logic              out_vld,
  output atan2_pkg::ctx_t   ctx_o
);
  import atan2_pkg::*;

  logic   vld_s [NSTEP+1];
  ctx_t   ctx_s [NSTEP+1];
  ctx_t   ctx_first;

  // seed with the highest coefficient
  always_comb begin
    ctx_first      = ctx_i;
    ctx_first.poly = COEF_Q[NCOEF-1];
  end

  assign vld_s[0] = in_vld;
  assign ctx_s[0] = ctx_first;

  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    logic                 m_vld;
    logic signed [QW-1:0] m_prod;
    ctx_t                 m_ctx;
    ctx_t                 a_nxt;
    ctx_t                 a_ctx_r;
    logic                 a_vld_r;

    atan2_qmul u_mul (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (vld_s[j]),
      .a_i     (ctx_s[j].sq),
      .b_i     (ctx_s[j].poly),
      .ctx_i   (ctx_s[j]),
      .out_vld (m_vld),
      .prod_o  (m_prod),
      .ctx_o   (m_ctx)
    );

    // add the next lower coefficient
    always_comb begin
      a_nxt      = m_ctx;
      a_nxt.poly = COEF_Q[NCOEF-2-j] + m_prod;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_vld_r <= 1'b0;
      end else if (en) begin
        a_vld_r <= m_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_ctx_r <= a_nxt;
      end
    end

    assign vld_s[j+1] = a_vld_r;
    assign ctx_s[j+1] = a_ctx_r;
  end

  assign out_vld = vld_s[NSTEP];
  assign ctx_o   = ctx_s[NSTEP];

endmodule

// ===== rtl/atan2_chk.sv =====
// port-level checker for the arctangent pipeline, bound to the top level
module atan2_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [atan2_pkg::OUT_TD_W-1:0]    out_tdata,
  input logic                              out_tuser
);
  import atan2_pkg::*;

  // held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // input side is open whenever no result waits
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // undefined result carries a zero angle
  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("undefined result with nonzero angle");

  // angle stays within -pi..pi
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[OUT_W-1:0]) <= $signed(ANGLE_MAX)) &&
                   ($signed(out_tdata[OUT_W-1:0]) >= -$signed(ANGLE_MAX)))
    else $error("angle out of range");

endmodule

bind two_argument_arctangent atan2_chk u_atan2_chk (.*);
